/* hw/rtl/page_frame_fifo_lru_replacer_defines.svh */
// ---------------------------------------------------------------------------
// Page frame replacer assertion macros
// Shared property shorthands for the replacer's checker.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAME_FIFO_LRU_REPLACER_DEFINES_SVH
`define PAGE_FRAME_FIFO_LRU_REPLACER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pfl_pkg.sv */
// ---------------------------------------------------------------------------
// Page frame replacer package
// Shared widths, register indexes, control bundles and helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package pfl_pkg;

  localparam int unsigned NUM_FRAMES_DEF       = 64;
  localparam int unsigned MAX_PROCESSES_DEF    = 16;
  localparam int unsigned PAGE_OFFSET_BITS_DEF = 12;

  localparam int unsigned PID_W      = 4;
  localparam int unsigned PID_RANGE  = 16;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned VPAGE_W    = 20;
  localparam int unsigned FIU_W      = 7;
  localparam int unsigned OCC_OUT_W  = 7;
  localparam int unsigned CNT_W      = 32;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_USED_W  = 2 + PID_W + VPAGE_W + OCC_OUT_W + 3 * CNT_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'd1;

  localparam logic             POLICY_FIFO  = 1'b0;
  localparam logic             POLICY_LRU   = 1'b1;
  localparam logic [FIU_W-1:0] FRAMES_RESET = 7'd64;

  // Per-cell controls driven by the sequencer.
  typedef struct packed {
    logic cmp_en;    // capture tag match against the pending request
    logic shift_ok;  // update cycle that may move entries toward the back
  } cell_ctrl_t;

  // Counter bank controls.
  typedef struct packed {
    logic rd_en;
    logic upd_en;
    logic is_hit;
  } cnt_ctrl_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/pfl_cell.sv */
// ---------------------------------------------------------------------------
// Page frame replacer cell
// One position of the recency row: holds a tag, matches it, shifts it back.
// ---------------------------------------------------------------------------
`default_nettype none

module pfl_cell #(
  parameter int unsigned PAGE_W = 20,
  parameter int unsigned OCC_W  = 7,
  parameter int unsigned IDX    = 0
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  pfl_pkg::cell_ctrl_t     ctrl_i,
  input  wire [OCC_W-1:0]         occ_i,
  input  wire [pfl_pkg::PID_W-1:0] req_pid_i,
  input  wire [PAGE_W-1:0]        req_page_i,
  input  wire [pfl_pkg::PID_W-1:0] prev_pid_i,
  input  wire [PAGE_W-1:0]        prev_page_i,
  input  wire                     seen_i,
  output logic [pfl_pkg::PID_W-1:0] pid_o,
  output logic [PAGE_W-1:0]       page_o,
  output logic                    seen_o,
  output logic [pfl_pkg::PID_W-1:0] vic_pid_o,
  output logic [PAGE_W-1:0]       vic_page_o
);

  logic [pfl_pkg::PID_W-1:0] pid_q;
  logic [PAGE_W-1:0]         page_q;
  logic                      match_q;
  logic                      valid;
  logic                      tail;

  // Position IDX holds a page while the occupancy is above it.
  assign valid = occ_i > OCC_W'(IDX);
  assign tail  = occ_i == OCC_W'(IDX + 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= valid && (pid_q == req_pid_i) && (page_q == req_page_i);
    end
  end

  // Entries in front of the hit (or all of them on a miss) move back one place.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_ok && !seen_i) begin
      pid_q  <= prev_pid_i;
      page_q <= prev_page_i;
    end
  end

  assign seen_o     = seen_i | match_q;
  assign pid_o      = pid_q;
  assign page_o     = page_q;
  assign vic_pid_o  = tail ? pid_q : '0;
  assign vic_page_o = tail ? page_q : '0;

endmodule

`default_nettype wire

/* hw/rtl/pfl_counters.sv */
// ---------------------------------------------------------------------------
// Page frame replacer counters
// Saturating per-process hit, fault and access counters.
// ---------------------------------------------------------------------------
`default_nettype none

module pfl_counters #(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned IDX_W         = 4
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  pfl_pkg::cnt_ctrl_t         ctrl_i,
  input  wire [IDX_W-1:0]            idx_i,
  output logic [pfl_pkg::CNT_W-1:0]  hits_o,
  output logic [pfl_pkg::CNT_W-1:0]  faults_o,
  output logic [pfl_pkg::CNT_W-1:0]  accesses_o
);

  logic [pfl_pkg::CNT_W-1:0] hit_cnt_q   [MAX_PROCESSES];
  logic [pfl_pkg::CNT_W-1:0] fault_cnt_q [MAX_PROCESSES];
  logic [pfl_pkg::CNT_W-1:0] acc_cnt_q   [MAX_PROCESSES];
  logic [pfl_pkg::CNT_W-1:0] rd_hit_q, rd_fault_q, rd_acc_q;
  logic [pfl_pkg::CNT_W-1:0] hit_nxt, fault_nxt, acc_nxt;

  // The selected counters are read into registers ahead of the update.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_hit_q   <= hit_cnt_q[idx_i];
      rd_fault_q <= fault_cnt_q[idx_i];
      rd_acc_q   <= acc_cnt_q[idx_i];
    end
  end

  assign hit_nxt   = pfl_pkg::sat_inc(rd_hit_q);
  assign fault_nxt = pfl_pkg::sat_inc(rd_fault_q);
  assign acc_nxt   = pfl_pkg::sat_inc(rd_acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PROCESSES; i++) begin
        hit_cnt_q[i]   <= '0;
        fault_cnt_q[i] <= '0;
        acc_cnt_q[i]   <= '0;
      end
    end else if (ctrl_i.upd_en) begin
      acc_cnt_q[idx_i] <= acc_nxt;
      if (ctrl_i.is_hit) begin
        hit_cnt_q[idx_i] <= hit_nxt;
      end else begin
        fault_cnt_q[idx_i] <= fault_nxt;
      end
    end
  end

  assign hits_o     = ctrl_i.is_hit ? hit_nxt : rd_hit_q;
  assign faults_o   = ctrl_i.is_hit ? rd_fault_q : fault_nxt;
  assign accesses_o = acc_nxt;

endmodule

`default_nettype wire

/* hw/rtl/page_frame_fifo_lru_replacer.sv */
// ---------------------------------------------------------------------------
// Page frame FIFO/LRU replacer
// Fully associative frame set kept as a row of cells in recency (LRU) or insertion (FIFO) order.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake                     Contents
//  s_axis    in         s_axis_tvalid/s_axis_tready   process id, virtual address
//  m_axis    out        m_axis_tvalid/m_axis_tready   hit, victim, occupancy, counters
//  cfg       in         cfg_valid_i/cfg_ready_o       register index, write data
//
//  Each request has a compare state (match its tag in every cell and read its
//  process counters) and an update state (shift the cell row, write the counters).
//  A new request can be taken in the update state of the request before it.
//  Reset empties all frames, clears the counters and selects LRU with 64 frames.
//  The update waits while the result register holds a result not yet taken.
// ---------------------------------------------------------------------------
`default_nettype none

module page_frame_fifo_lru_replacer #(
  parameter int unsigned NUM_FRAMES       = pfl_pkg::NUM_FRAMES_DEF,
  parameter int unsigned MAX_PROCESSES    = pfl_pkg::MAX_PROCESSES_DEF,
  parameter int unsigned PAGE_OFFSET_BITS = pfl_pkg::PAGE_OFFSET_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] process_id, [35:4] virtual_address
  input  wire [pfl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // [0] is_hit, [1] evicted, [5:2] victim_process, [25:6] victim_page,
  // [32:26] frames_occupied, [64:33] process_hits, [96:65] process_faults,
  // [128:97] process_accesses
  output logic [pfl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [pfl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [pfl_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned PAGE_W = pfl_pkg::ADDR_W - PAGE_OFFSET_BITS;
  localparam int unsigned OCC_W  = $clog2(NUM_FRAMES + 1);
  localparam int unsigned LIM_W  = (OCC_W > pfl_pkg::FIU_W) ? OCC_W : pfl_pkg::FIU_W;
  localparam int unsigned IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned PID_W  = pfl_pkg::PID_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]                state_q, state_d;
  logic                      policy_q;
  logic [pfl_pkg::FIU_W-1:0] fiu_q;
  logic [PID_W-1:0]          req_pid_q;
  logic [PAGE_W-1:0]         req_page_q;
  logic [OCC_W-1:0]          occ_q, occ_d;
  logic                      full_q;
  logic [PID_W-1:0]          vic_pid_q;
  logic [PAGE_W-1:0]         vic_page_q;

  logic                      in_fire, out_free, upd_fire;
  logic                      is_hit, evict;
  logic [LIM_W-1:0]          limit;
  logic [LIM_W-1:0]          fiu_ext;

  pfl_pkg::cell_ctrl_t       cell_ctrl;
  pfl_pkg::cnt_ctrl_t        cnt_ctrl;

  logic [PID_W-1:0]          c_pid      [NUM_FRAMES];
  logic [PAGE_W-1:0]         c_page     [NUM_FRAMES];
  logic [PID_W-1:0]          c_vic_pid  [NUM_FRAMES];
  logic [PAGE_W-1:0]         c_vic_page [NUM_FRAMES];
  logic [NUM_FRAMES:0]       seen;
  logic [PID_W-1:0]          vic_pid_or;
  logic [PAGE_W-1:0]         vic_page_or;

  logic [IDX_W-1:0]          ci_lut [pfl_pkg::PID_RANGE];
  logic [IDX_W-1:0]          cnt_idx;
  logic [pfl_pkg::CNT_W-1:0] cnt_hits, cnt_faults, cnt_acc;

  logic                      out_valid_q;
  logic                      out_hit_q, out_evict_q;
  logic [PID_W-1:0]          out_vpid_q;
  logic [pfl_pkg::VPAGE_W-1:0]   out_vpage_q;
  logic [pfl_pkg::OCC_OUT_W-1:0] out_occ_q;
  logic [pfl_pkg::CNT_W-1:0] out_hits_q, out_faults_q, out_acc_q;
  logic [31:0]               occ_wide, vpage_wide;

  // ---- configuration -------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= pfl_pkg::POLICY_LRU;
      fiu_q    <= pfl_pkg::FRAMES_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pfl_pkg::CFG_POLICY_MODE:   policy_q <= cfg_data_i[0];
        pfl_pkg::CFG_FRAMES_IN_USE: fiu_q    <= cfg_data_i[pfl_pkg::FIU_W-1:0];
        default: ;
      endcase
    end
  end

  // A limit of zero acts as one; a limit above the row acts as the row size.
  assign fiu_ext = LIM_W'(fiu_q);
  always_comb begin
    if (fiu_q == '0) begin
      limit = LIM_W'(1);
    end else if (fiu_ext > LIM_W'(NUM_FRAMES)) begin
      limit = LIM_W'(NUM_FRAMES);
    end else begin
      limit = fiu_ext;
    end
  end

  // ---- sequencer -----------------------------------------------------------
  assign out_free      = !out_valid_q || m_axis_tready;
  assign upd_fire      = (state_q == ST_UPD) && out_free;
  assign s_axis_tready = (state_q == ST_IDLE) || upd_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD: begin
        if (upd_fire) state_d = in_fire ? ST_CMP : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_pid_q  <= s_axis_tdata[PID_W-1:0];
      req_page_q <= s_axis_tdata[PID_W+PAGE_OFFSET_BITS +: PAGE_W];
    end
  end

  // ---- cell row --------------------------------------------------------------
  assign is_hit = seen[NUM_FRAMES];
  assign evict  = !is_hit && full_q;

  assign cell_ctrl.cmp_en   = (state_q == ST_CMP);
  assign cell_ctrl.shift_ok = upd_fire && (policy_q == pfl_pkg::POLICY_LRU || !is_hit);

  assign seen[0] = 1'b0;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    logic [PID_W-1:0]  prev_pid;
    logic [PAGE_W-1:0] prev_page;

    if (g == 0) begin : g_head
      assign prev_pid  = req_pid_q;
      assign prev_page = req_page_q;
    end else begin : g_body
      assign prev_pid  = c_pid[g-1];
      assign prev_page = c_page[g-1];
    end

    pfl_cell #(
      .PAGE_W (PAGE_W),
      .OCC_W  (OCC_W),
      .IDX    (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .occ_i       (occ_q),
      .req_pid_i   (req_pid_q),
      .req_page_i  (req_page_q),
      .prev_pid_i  (prev_pid),
      .prev_page_i (prev_page),
      .seen_i      (seen[g]),
      .pid_o       (c_pid[g]),
      .page_o      (c_page[g]),
      .seen_o      (seen[g+1]),
      .vic_pid_o   (c_vic_pid[g]),
      .vic_page_o  (c_vic_page[g])
    );
  end

  // Only the cell at the back drives a nonzero victim.
  always_comb begin
    vic_pid_or  = '0;
    vic_page_or = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      vic_pid_or  = vic_pid_or | c_vic_pid[i];
      vic_page_or = vic_page_or | c_vic_page[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CMP) begin
      full_q     <= LIM_W'(occ_q) >= limit;
      vic_pid_q  <= vic_pid_or;
      vic_page_q <= vic_page_or;
    end
  end

  assign occ_d = (upd_fire && !is_hit && !full_q) ? occ_q + OCC_W'(1) : occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // ---- counters --------------------------------------------------------------
  for (genvar p = 0; p < pfl_pkg::PID_RANGE; p++) begin : g_ci
    localparam int unsigned CI = p % MAX_PROCESSES;
    assign ci_lut[p] = IDX_W'(CI);
  end

  assign cnt_idx         = ci_lut[req_pid_q];
  assign cnt_ctrl.rd_en  = (state_q == ST_CMP);
  assign cnt_ctrl.upd_en = upd_fire;
  assign cnt_ctrl.is_hit = is_hit;

  pfl_counters #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .IDX_W         (IDX_W)
  ) u_counters (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (cnt_ctrl),
    .idx_i      (cnt_idx),
    .hits_o     (cnt_hits),
    .faults_o   (cnt_faults),
    .accesses_o (cnt_acc)
  );

  // ---- result register -------------------------------------------------------
  assign occ_wide   = 32'(occ_d);
  assign vpage_wide = 32'(vic_page_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      out_hit_q    <= is_hit;
      out_evict_q  <= evict;
      out_vpid_q   <= evict ? vic_pid_q : '0;
      out_vpage_q  <= evict ? vpage_wide[pfl_pkg::VPAGE_W-1:0] : '0;
      out_occ_q    <= occ_wide[pfl_pkg::OCC_OUT_W-1:0];
      out_hits_q   <= cnt_hits;
      out_faults_q <= cnt_faults;
      out_acc_q    <= cnt_acc;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{pfl_pkg::OUT_PAD_W{1'b0}}, out_acc_q, out_faults_q, out_hits_q,
                          out_occ_q, out_vpage_q, out_vpid_q, out_evict_q, out_hit_q};

endmodule

`default_nettype wire

/* hw/rtl/pfl_checker.sv */
// ---------------------------------------------------------------------------
// Page frame replacer checker
// Port-level properties of the replacer, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "page_frame_fifo_lru_replacer_defines.svh"

module pfl_checker (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             s_axis_tvalid,
  input wire                             s_axis_tready,
  input wire                             m_axis_tvalid,
  input wire                             m_axis_tready,
  input wire [pfl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // A stalled result keeps its contents.
  `PFL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // A hit never evicts.
  `PFL_ASSERT_IMP(a_hit_no_evict, clk_i, rst_ni, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]), "hit reported with eviction")

  // Without an eviction the victim fields read zero.
  `PFL_ASSERT_IMP(a_victim_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[1], m_axis_tdata[25:2] == 24'd0, "victim set without eviction")

  // The compare cycle after a request never takes another request.
  `PFL_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken during compare")

endmodule

bind page_frame_fifo_lru_replacer pfl_checker u_pfl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
